FILE: hdl/ckso_pkg.sv
// ----------------------------------------------------------------------------
// ckso_pkg
// Shared constants, codes and types of the color-keyed sprite overlay.
// ----------------------------------------------------------------------------
package ckso_pkg;

  localparam int unsigned SPRITE_WIDTH  = 64;
  localparam int unsigned SPRITE_HEIGHT = 64;

  localparam int unsigned COL_W      = $clog2(SPRITE_WIDTH);
  localparam int unsigned ROW_W      = $clog2(SPRITE_HEIGHT);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned FW_W       = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SUM_W      = POS_W + 1;
  localparam int unsigned PROD_W     = SUM_W + FW_W;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_ROW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LUMA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CB      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CR      = 3'd5;

  localparam logic [FW_W-1:0]  RST_FRAME_WIDTH = 13'd640;
  localparam logic [POS_W-1:0] RST_POS_ROW     = 12'd0;
  localparam logic [POS_W-1:0] RST_POS_COL     = 12'd0;
  localparam logic [KEY_W-1:0] RST_KEY_LUMA    = 8'd16;
  localparam logic [KEY_W-1:0] RST_KEY_CB      = 8'd128;
  localparam logic [KEY_W-1:0] RST_KEY_CR      = 8'd128;

  localparam logic [COL_W-1:0] LUMA_LAST_COL   = COL_W'(SPRITE_WIDTH - 1);
  localparam logic [ROW_W-1:0] LUMA_LAST_ROW   = ROW_W'(SPRITE_HEIGHT - 1);
  localparam logic [COL_W-1:0] CHROMA_LAST_COL = COL_W'(SPRITE_WIDTH / 2 - 1);
  localparam logic [ROW_W-1:0] CHROMA_LAST_ROW = ROW_W'(SPRITE_HEIGHT / 2 - 1);

  typedef struct packed {
    logic [FW_W-1:0]  frame_width;
    logic [POS_W-1:0] pos_row;
    logic [POS_W-1:0] pos_col;
    logic [KEY_W-1:0] key_luma;
    logic [KEY_W-1:0] key_cb;
    logic [KEY_W-1:0] key_cr;
  } cfg_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } pos_t;

  typedef struct packed {
    pos_t             pos;
    logic [PIX_W-1:0] pix;
    logic             done;
  } stage_t;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [ADDR_W-1:0]  frame_address;
    logic [PIX_W-1:0]   write_data;
    logic               write_enable;
    logic               sprite_done;
  } res_t;

endpackage

FILE: hdl/ckso_if.sv
// ----------------------------------------------------------------------------
// ckso_pix_if / ckso_res_if
// Valid/ready channels for sprite bytes in and frame writes out.
// ----------------------------------------------------------------------------
interface ckso_pix_if;
  import ckso_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ckso_res_if;
  import ckso_pkg::*;

  logic               valid;
  logic               ready;
  logic [PLANE_W-1:0] plane;
  logic [ADDR_W-1:0]  frame_address;
  logic [PIX_W-1:0]   write_data;
  logic               write_enable;
  logic               sprite_done;

  modport source (
    output valid, output plane, output frame_address, output write_data,
    output write_enable, output sprite_done, input ready
  );
  modport sink (
    input valid, input plane, input frame_address, input write_data,
    input write_enable, input sprite_done, output ready
  );
endinterface

FILE: hdl/ckso_cfg_regs.sv
// ----------------------------------------------------------------------------
// ckso_cfg_regs
// Configuration register file: frame stride, sprite offset and plane keys.
// ----------------------------------------------------------------------------
module ckso_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ckso_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ckso_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ckso_pkg::cfg_t                 cfg_o
);
  import ckso_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width <= RST_FRAME_WIDTH;
      cfg_q.pos_row     <= RST_POS_ROW;
      cfg_q.pos_col     <= RST_POS_COL;
      cfg_q.key_luma    <= RST_KEY_LUMA;
      cfg_q.key_cb      <= RST_KEY_CB;
      cfg_q.key_cr      <= RST_KEY_CR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data_i[FW_W-1:0];
        CFG_POS_ROW:     cfg_q.pos_row     <= cfg_data_i[POS_W-1:0];
        CFG_POS_COL:     cfg_q.pos_col     <= cfg_data_i[POS_W-1:0];
        CFG_KEY_LUMA:    cfg_q.key_luma    <= cfg_data_i[KEY_W-1:0];
        CFG_KEY_CB:      cfg_q.key_cb      <= cfg_data_i[KEY_W-1:0];
        CFG_KEY_CR:      cfg_q.key_cr      <= cfg_data_i[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/ckso_scan.sv
// ----------------------------------------------------------------------------
// ckso_scan
// Plane/row/column counters walking the sprite in Y, U, V stored order.
// ----------------------------------------------------------------------------
module ckso_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  output ckso_pkg::pos_t pos_o,
  output logic           last_o
);
  import ckso_pkg::*;

  pos_t pos_q, pos_d;
  logic luma, last_col, last_row;

  assign luma     = (pos_q.plane == PLANE_Y);
  assign last_col = luma ? (pos_q.col == LUMA_LAST_COL) : (pos_q.col == CHROMA_LAST_COL);
  assign last_row = luma ? (pos_q.row == LUMA_LAST_ROW) : (pos_q.row == CHROMA_LAST_ROW);

  always_comb begin
    pos_d = pos_q;
    if (advance_i) begin
      if (last_col) begin
        pos_d.col = '0;
        if (last_row) begin
          pos_d.row   = '0;
          pos_d.plane = (pos_q.plane == PLANE_V) ? PLANE_Y : pos_q.plane + PLANE_W'(1);
        end else begin
          pos_d.row = pos_q.row + ROW_W'(1);
        end
      end else begin
        pos_d.col = pos_q.col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign pos_o  = pos_q;
  assign last_o = (pos_q.plane == PLANE_V) && last_row && last_col;

endmodule

FILE: hdl/ckso_addr.sv
// ----------------------------------------------------------------------------
// ckso_addr
// Frame address and key compare for one registered sprite byte.
// ----------------------------------------------------------------------------
module ckso_addr (
  input  ckso_pkg::cfg_t   cfg_i,
  input  ckso_pkg::stage_t stage_i,
  output ckso_pkg::res_t   res_o
);
  import ckso_pkg::*;

  logic              luma;
  logic [POS_W-1:0]  row_off, col_off;
  logic [SUM_W-1:0]  row_sum, col_sum;
  logic [PROD_W-1:0] prod, prod_adj;
  logic [KEY_W-1:0]  key;

  // chroma uses half offsets and half the luma stride
  assign luma     = (stage_i.pos.plane == PLANE_Y);
  assign row_off  = luma ? cfg_i.pos_row : (cfg_i.pos_row >> 1);
  assign col_off  = luma ? cfg_i.pos_col : (cfg_i.pos_col >> 1);
  assign row_sum  = SUM_W'(stage_i.pos.row) + SUM_W'(row_off);
  assign col_sum  = SUM_W'(stage_i.pos.col) + SUM_W'(col_off);
  assign prod     = PROD_W'(row_sum) * PROD_W'(cfg_i.frame_width);
  assign prod_adj = luma ? prod : (prod >> 1);

  always_comb begin
    case (stage_i.pos.plane)
      PLANE_Y: key = cfg_i.key_luma;
      PLANE_U: key = cfg_i.key_cb;
      default: key = cfg_i.key_cr;
    endcase
  end

  assign res_o.plane         = stage_i.pos.plane;
  assign res_o.frame_address = prod_adj[ADDR_W-1:0] + ADDR_W'(col_sum);
  assign res_o.write_data    = stage_i.pix;
  assign res_o.write_enable  = (stage_i.pix != key);
  assign res_o.sprite_done   = stage_i.done;

endmodule

FILE: hdl/color_key_sprite_overlay.sv
// ----------------------------------------------------------------------------
// color_key_sprite_overlay
// Color-keyed overlay of a planar YUV420 sprite onto a frame.
// ----------------------------------------------------------------------------
// Feed the sprite one byte per beat: Y plane, then U, then V. Each byte gives
// one result beat with the target plane, frame address, the byte and a write
// enable that is low where the byte equals that plane's key. The block takes
// one byte per cycle while the result side is not stalled: an input register
// holding the byte and its scan position, then one stride multiply and address
// add into the result register. sprite_done marks the last V byte; the counters
// then start the next sprite. Write configuration only while the block is idle.
module color_key_sprite_overlay (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ckso_pix_if.sink                       pixel_i,
  ckso_res_if.source                     result_o,
  input  logic                           cfg_we_i,
  input  logic [ckso_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ckso_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ckso_pkg::*;

  cfg_t   cfg;
  pos_t   pos;
  logic   last;
  logic   in_fire, s1_adv, out_free;
  logic   s1_valid_q, out_valid_q;
  stage_t s1_q;
  res_t   res, res_q;

  ckso_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ckso_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_fire),
    .pos_o     (pos),
    .last_o    (last)
  );

  ckso_addr u_addr (
    .cfg_i   (cfg),
    .stage_i (s1_q),
    .res_o   (res)
  );

  assign out_free      = !out_valid_q || result_o.ready;
  assign s1_adv        = s1_valid_q && out_free;
  assign pixel_i.ready = !s1_valid_q || out_free;
  assign in_fire       = pixel_i.valid && pixel_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pixel_i.ready) begin
        s1_valid_q <= pixel_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.pos  <= pos;
      s1_q.pix  <= pixel_i.pixel_value;
      s1_q.done <= last;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.plane         = res_q.plane;
  assign result_o.frame_address = res_q.frame_address;
  assign result_o.write_data    = res_q.write_data;
  assign result_o.write_enable  = res_q.write_enable;
  assign result_o.sprite_done   = res_q.sprite_done;

  a_done_on_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.sprite_done |-> res_q.plane == PLANE_V)
    else $error("sprite_done outside the V plane");

  a_luma_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.plane == PLANE_Y
      |-> res_q.write_enable == (res_q.write_data != cfg.key_luma))
    else $error("luma write enable disagrees with key");

  a_plane_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last && pos.plane == PLANE_V |=> pos.plane == PLANE_V)
    else $error("V plane left before its last byte");

  a_done_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last |=> pos == '0)
    else $error("scan did not restart after the last byte");

endmodule
